@@ sv/mvc_pkg.sv @@
`default_nettype none
package mvc_pkg;

    localparam int MaxSamples = 1024;
    localparam int CountW = $clog2(MaxSamples + 1);

    // Wide working width for the shared datapath (holds Dxx*Dyy and the scaled numerator).
    localparam int WideW = 132;

    // Result status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [1:0] STATUS_ZERO_VAR = 2'd2;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

    typedef struct packed {
        logic signed [15:0] sample_a;
        logic signed [15:0] sample_b;
        logic               last_sample;
    } mvc_in_t;

    typedef struct packed {
        logic signed [15:0] mean_first;
        logic signed [15:0] mean_second;
        logic        [30:0] var_first;
        logic        [30:0] var_second;
        logic signed [31:0] cov_value;
        logic signed [15:0] corr_value;
        logic        [10:0] pair_count;
        logic        [1:0]  status_code;
    } mvc_out_t;

endpackage
`default_nettype wire

@@ sv/mean_variance_correlation.sv @@
`default_nettype none
// Block statistics for paired Q8.8 samples: means, population variances,
// covariance and Pearson correlation (Q1.15, saturated).
// Input channel: a beat is taken on a rising edge with start high and busy low.
// A beat with last_sample low is absorbed into the running sums,
// so busy stays low and such beats may arrive in every cycle.
// A beat with last_sample high closes the block: busy rises and a sequencer
// drives one shared add/subtract-shift unit through the multiplications and
// divisions, one bit per cycle, and through the correlation search. The result then
// appears on result with done high for a single cycle, and the sums clear.
// Closing runs the sequencing steps, nine multiplies, two divides for the
// means, three for the variances and covariance, the correlation search over
// each of the 16 bits and one output step. When a variance numerator is zero
// the search is skipped.
// done is high in the first cycle after busy falls, and a new beat may be
// taken in that same cycle.
// The receiver cannot stall: a result is presented once and must be taken.
// Reset (rst_n low, asynchronous) clears all sums, the count and the sequencer.
// Pairs beyond MaxSamples in a block are dropped and the result reports overflow.
module mean_variance_correlation
    import mvc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire mvc_in_t  item,
    output logic          busy,
    output logic          done,
    output mvc_out_t      result
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MUL  = 9'b000000010,
        S_DIV  = 9'b000000100,
        S_SEQ  = 9'b000001000,
        S_QSQ  = 9'b000010000,
        S_QMUL = 9'b000100000,
        S_QCMP = 9'b001000000,
        S_OUT  = 9'b010000000,
        S_EMPT = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Running sums.
    logic signed [25:0] sx_reg, sy_reg;
    logic        [40:0] sxx_reg, syy_reg;
    logic signed [41:0] sxy_reg;
    logic [CountW-1:0]  cnt_reg;
    logic               ovf_reg;

    // Shared unit operands.
    logic [WideW-1:0] acc_reg;   // product / remainder
    logic [WideW-1:0] opa_reg;   // multiplicand / divisor (shifted)
    logic [WideW-1:0] opb_reg;   // multiplier / quotient
    logic [7:0]       bit_reg;

    // Sequence scratch.
    logic [4:0]        step_reg;
    logic [WideW-1:0]  t1_reg, t2_reg, t3_reg;
    logic signed [66:0] dxx_reg, dyy_reg, dxy_reg;
    logic [WideW-1:0]  prod_reg, num_reg;
    logic [15:0]       q_reg;
    logic [4:0]        qb_reg;
    logic              neg_reg;
    mvc_out_t          res_reg;

    logic accept;
    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);
    assign result = res_reg;

    logic take;
    assign take = (cnt_reg != CountW'(MaxSamples));

    logic signed [31:0] pa, pb, pab;
    assign pa  = item.sample_a * item.sample_a;
    assign pb  = item.sample_b * item.sample_b;
    assign pab = item.sample_a * item.sample_b;

    function automatic logic [WideW-1:0] absw(input logic signed [66:0] v);
        logic [66:0] m;
        m = v[66] ? 67'(-v) : 67'(v);
        return WideW'(m);
    endfunction

    function automatic logic [WideW-1:0] sx(input logic signed [66:0] v);
        return WideW'(v);
    endfunction

    // One multiply step: add when multiplier bit is set.
    logic [WideW-1:0] mul_acc;
    assign mul_acc = opb_reg[0] ? acc_reg + opa_reg : acc_reg;
    // One restoring division step.
    logic [WideW:0] div_trial;
    assign div_trial = {1'b0, acc_reg} - {1'b0, opa_reg};

    logic signed [66:0] nsx, nsy;
    assign nsx = 67'(sx_reg);
    assign nsy = 67'(sy_reg);

    logic [15:0] qt;
    assign qt = q_reg | (16'd1 << qb_reg[3:0]);

    // Sequencer and datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sx_reg <= '0; sy_reg <= '0; sxx_reg <= '0; syy_reg <= '0; sxy_reg <= '0;
            cnt_reg <= '0; ovf_reg <= 1'b0; done <= 1'b0; step_reg <= '0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (take)
                        begin
                            sx_reg  <= sx_reg + 26'(item.sample_a);
                            sy_reg  <= sy_reg + 26'(item.sample_b);
                            sxx_reg <= sxx_reg + 41'(unsigned'(pa));
                            syy_reg <= syy_reg + 41'(unsigned'(pb));
                            sxy_reg <= sxy_reg + 42'(pab);
                            cnt_reg <= cnt_reg + CountW'(1);
                        end
                        else
                            ovf_reg <= 1'b1;
                        if (item.last_sample)
                        begin
                            if (cnt_reg == '0 && !take)
                                state_reg <= S_EMPT;
                            else if (cnt_reg == '0)
                            begin
                                // a single pair: sums are the pair itself
                                state_reg <= S_SEQ;
                                step_reg  <= '0;
                            end
                            else
                            begin
                                state_reg <= S_SEQ;
                                step_reg  <= '0;
                            end
                        end
                    end
                end
                S_EMPT:
                begin
                    res_reg <= '0;
                    res_reg.status_code <= STATUS_EMPTY;
                    done <= 1'b1;
                    sx_reg <= '0; sy_reg <= '0; sxx_reg <= '0; syy_reg <= '0;
                    sxy_reg <= '0; cnt_reg <= '0; ovf_reg <= 1'b0;
                    state_reg <= S_IDLE;
                end
                S_MUL:
                begin
                    acc_reg <= mul_acc;
                    opa_reg <= opa_reg << 1;
                    opb_reg <= opb_reg >> 1;
                    bit_reg <= bit_reg - 8'd1;
                    if (bit_reg == 8'd1)
                        state_reg <= S_SEQ;
                end
                S_DIV:
                begin
                    if (!div_trial[WideW])
                    begin
                        acc_reg <= div_trial[WideW-1:0];
                        opb_reg <= (opb_reg << 1) | WideW'(1);
                    end
                    else
                        opb_reg <= opb_reg << 1;
                    opa_reg <= opa_reg >> 1;
                    bit_reg <= bit_reg - 8'd1;
                    if (bit_reg == 8'd1)
                        state_reg <= S_SEQ;
                end
                S_SEQ:
                begin
                    step_reg <= step_reg + 5'd1;
                    state_reg <= S_MUL;
                    acc_reg <= '0;
                    bit_reg <= 8'd67;
                    case (step_reg)
                        5'd0: begin opa_reg <= WideW'(sxx_reg); opb_reg <= WideW'(cnt_reg); end
                        5'd1: begin t1_reg <= acc_reg; opa_reg <= sx(nsx); opb_reg <= sx(nsx); end
                        5'd2: begin dxx_reg <= 67'(t1_reg - acc_reg);
                                    opa_reg <= WideW'(syy_reg); opb_reg <= WideW'(cnt_reg); end
                        5'd3: begin t1_reg <= acc_reg; opa_reg <= sx(nsy); opb_reg <= sx(nsy); end
                        5'd4: begin dyy_reg <= 67'(t1_reg - acc_reg);
                                    opa_reg <= sx(67'(sxy_reg)); opb_reg <= WideW'(cnt_reg); end
                        5'd5: begin t1_reg <= acc_reg; opa_reg <= sx(nsx); opb_reg <= sx(nsy); end
                        5'd6: begin dxy_reg <= 67'(t1_reg - acc_reg);
                                    opa_reg <= WideW'(cnt_reg); opb_reg <= WideW'(cnt_reg); end
                        5'd7: begin t2_reg <= acc_reg;
                                    // mean_first = |Sx| / n
                                    state_reg <= S_DIV; bit_reg <= 8'd26;
                                    acc_reg <= absw(nsx); opb_reg <= '0;
                                    opa_reg <= WideW'(cnt_reg) << 25; end
                        5'd8: begin res_reg.mean_first <= 16'(sx_reg[25] ? -opb_reg : opb_reg);
                                    state_reg <= S_DIV; bit_reg <= 8'd26;
                                    acc_reg <= absw(nsy); opb_reg <= '0;
                                    opa_reg <= WideW'(cnt_reg) << 25; end
                        5'd9: begin res_reg.mean_second <= 16'(sy_reg[25] ? -opb_reg : opb_reg);
                                    state_reg <= S_DIV; bit_reg <= 8'd67;
                                    acc_reg <= absw(dxx_reg); opb_reg <= '0;
                                    opa_reg <= t2_reg << 66; end
                        5'd10: begin res_reg.var_first <= 31'(opb_reg);
                                    state_reg <= S_DIV; bit_reg <= 8'd67;
                                    acc_reg <= absw(dyy_reg); opb_reg <= '0;
                                    opa_reg <= t2_reg << 66; end
                        5'd11: begin res_reg.var_second <= 31'(opb_reg);
                                    state_reg <= S_DIV; bit_reg <= 8'd67;
                                    acc_reg <= absw(dxy_reg); opb_reg <= '0;
                                    opa_reg <= t2_reg << 66; end
                        5'd12: begin res_reg.cov_value <= 32'(dxy_reg[66] ? -opb_reg : opb_reg);
                                    opa_reg <= absw(dxx_reg); opb_reg <= absw(dyy_reg); end
                        5'd13: begin prod_reg <= acc_reg;
                                    opa_reg <= absw(dxy_reg); opb_reg <= absw(dxy_reg); end
                        5'd14: begin num_reg <= acc_reg << 30;
                                    neg_reg <= dxy_reg[66];
                                    q_reg <= '0; qb_reg <= 5'd15;
                                    state_reg <= S_QSQ; end
                        default: state_reg <= S_OUT;
                    endcase
                    if (step_reg == 5'd14 && (dxx_reg == '0 || dyy_reg == '0))
                        state_reg <= S_OUT;
                end
                // Correlation search: test q|bit squared times prod against num.
                S_QSQ:
                begin
                    acc_reg <= '0; bit_reg <= 8'd32;
                    opa_reg <= WideW'(qt); opb_reg <= WideW'(qt);
                    state_reg <= S_QMUL;
                    t3_reg <= '0;
                end
                S_QMUL:
                begin
                    acc_reg <= mul_acc;
                    opa_reg <= opa_reg << 1;
                    opb_reg <= opb_reg >> 1;
                    bit_reg <= bit_reg - 8'd1;
                    if (bit_reg == 8'd1)
                    begin
                        if (t3_reg == '0)
                        begin
                            // second pass: (q*q) times prod
                            t3_reg <= '1;
                            opa_reg <= prod_reg;
                            opb_reg <= mul_acc;
                            acc_reg <= '0;
                            bit_reg <= 8'd32;
                        end
                        else
                            state_reg <= S_QCMP;
                    end
                end
                S_QCMP:
                begin
                    if (acc_reg <= num_reg)
                        q_reg <= qt;
                    qb_reg <= qb_reg - 5'd1;
                    state_reg <= (qb_reg == '0) ? S_OUT : S_QSQ;
                end
                S_OUT:
                begin
                    if (dxx_reg == '0 || dyy_reg == '0)
                    begin
                        res_reg.corr_value <= '0;
                        res_reg.status_code <= ovf_reg ? STATUS_OVERFLOW : STATUS_ZERO_VAR;
                    end
                    else
                    begin
                        res_reg.corr_value <= neg_reg ? 16'(-q_reg)
                                            : (q_reg[15] ? 16'h7FFF : q_reg);
                        res_reg.status_code <= ovf_reg ? STATUS_OVERFLOW : STATUS_OK;
                    end
                    res_reg.pair_count <= 11'(cnt_reg);
                    done <= 1'b1;
                    sx_reg <= '0; sy_reg <= '0; sxx_reg <= '0; syy_reg <= '0;
                    sxy_reg <= '0; cnt_reg <= '0; ovf_reg <= 1'b0;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // state_next mirrors the register for the assertions below.
    always_comb
    begin
        state_next = state_reg;
    end

`ifndef SYNTHESIS
    a_no_done_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy)) else $error("result without a closing beat");
    a_clear_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> cnt_reg == '0) else $error("sums not cleared after result");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CountW'(MaxSamples)) else $error("pair count above limit");
    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("still busy after result");
    a_state_stable: assert property (@(posedge clk) disable iff (!rst_n)
        state_next == state_reg) else $error("state copy mismatch");
`endif

endmodule
`default_nettype wire
